// File: rtl/ezr_pkg.sv
// Package for the ZYX Euler vector rotation block.
// Holds the fixed trig field width, the matrix and vector sizes and a small helper.
// No dependencies; imported by ezr_matvec and euler_zyx_vector_rotate.
`default_nettype none

package ezr_pkg;

  // Width of every cosine and sine input field (signed, fixed by the interface).
  localparam int TRIG_W = 16;

  // Three vector components and a 3x3 matrix stored row by row.
  localparam int VEC_N = 3;
  localparam int MAT_N = VEC_N * VEC_N;

  // Elaboration-time maximum, used to size intermediate words.
  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ezr_matvec.sv
// Three-stage matrix times vector unit: products, row sums, then round and saturate.
// Depends on ezr_pkg; instantiated by euler_zyx_vector_rotate.
`default_nettype none

module ezr_matvec #(
  parameter int VEC_WIDTH = 24,
  parameter int ENT_W     = 22,
  parameter int FRAC_BITS = 14
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic signed [ENT_W-1:0]            mat_i [ezr_pkg::MAT_N],
  input  logic signed [VEC_WIDTH-1:0]        vec_i [ezr_pkg::VEC_N],
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic signed [VEC_WIDTH-1:0]        out_x_o,
  output logic signed [VEC_WIDTH-1:0]        out_y_o,
  output logic signed [VEC_WIDTH-1:0]        out_z_o,
  output logic                               saturated_o
);
  import ezr_pkg::*;

  localparam int PW = ENT_W + VEC_WIDTH;
  localparam int AW = PW + 2;
  localparam logic signed [AW-1:0] RND_ACC = AW'(1) << (FRAC_BITS - 1);
  localparam logic signed [AW-1:0] SAT_HI =
    {{(AW - VEC_WIDTH + 1){1'b0}}, {(VEC_WIDTH - 1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO =
    {{(AW - VEC_WIDTH + 1){1'b1}}, {(VEC_WIDTH - 1){1'b0}}};

  logic [2:0] vld_q, vld_d;
  logic [2:0] en;

  logic signed [PW-1:0]        prod_q [MAT_N];
  logic signed [PW-1:0]        prod_d [MAT_N];
  logic signed [AW-1:0]        acc_q  [VEC_N];
  logic signed [AW-1:0]        acc_d  [VEC_N];
  logic signed [VEC_WIDTH-1:0] res_q  [VEC_N];
  logic signed [VEC_WIDTH-1:0] res_d  [VEC_N];
  logic                        sat_q, sat_d;

  // A stage loads when it is empty or its successor moves on.
  assign en[2]   = !vld_q[2] || !stall_i;
  assign en[1]   = !vld_q[1] || en[2];
  assign en[0]   = !vld_q[0] || en[1];
  assign stall_o = !en[0];

  always_comb begin
    vld_d[0] = en[0] ? valid_i  : vld_q[0];
    vld_d[1] = en[1] ? vld_q[0] : vld_q[1];
    vld_d[2] = en[2] ? vld_q[1] : vld_q[2];
  end

  always_comb begin
    for (int i = 0; i < VEC_N; i++) begin
      for (int j = 0; j < VEC_N; j++) begin
        prod_d[i*VEC_N+j] = PW'(mat_i[i*VEC_N+j]) * PW'(vec_i[j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < VEC_N; i++) begin
      acc_d[i] = AW'(prod_q[i*VEC_N]) + AW'(prod_q[i*VEC_N+1])
               + AW'(prod_q[i*VEC_N+2]) + RND_ACC;
    end
  end

  always_comb begin
    logic signed [AW-1:0] r;
    sat_d = 1'b0;
    for (int i = 0; i < VEC_N; i++) begin
      r = acc_q[i] >>> FRAC_BITS;
      if (r > SAT_HI) begin
        res_d[i] = VEC_WIDTH'(SAT_HI);
        sat_d    = 1'b1;
      end else if (r < SAT_LO) begin
        res_d[i] = VEC_WIDTH'(SAT_LO);
        sat_d    = 1'b1;
      end else begin
        res_d[i] = VEC_WIDTH'(r);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_q <= prod_d;
    end
    if (en[1]) begin
      acc_q <= acc_d;
    end
    if (en[2]) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign valid_o     = vld_q[2];
  assign out_x_o     = res_q[0];
  assign out_y_o     = res_q[1];
  assign out_z_o     = res_q[2];
  assign saturated_o = sat_q;

  // A stall reaches the input only when every stage holds a request.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (vld_q[0] && vld_q[1] && vld_q[2]))
    else $error("ezr_matvec: input stalled with an empty stage");

  // A request in the product stage that may advance is in the sum stage next.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && en[1]) |=> vld_q[1])
    else $error("ezr_matvec: request lost between product and sum stages");

  // A clipped result has at least one component at a range limit.
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && saturated_o) |->
      (out_x_o == VEC_WIDTH'(SAT_HI) || out_x_o == VEC_WIDTH'(SAT_LO) ||
       out_y_o == VEC_WIDTH'(SAT_HI) || out_y_o == VEC_WIDTH'(SAT_LO) ||
       out_z_o == VEC_WIDTH'(SAT_HI) || out_z_o == VEC_WIDTH'(SAT_LO)))
    else $error("ezr_matvec: saturated flag without a clipped component");

endmodule

`default_nettype wire

// File: rtl/euler_zyx_vector_rotate.sv
// Six register stages: pair products, triple products and matrix entries here,
// then products, row sums and rounded results in ezr_matvec, in that order.
// Throughput: one request per cycle while stall_i is low; each of the six stages
// holds its own valid bit, so bubbles are squeezed out and a stage holds still only
// while its successor is full and cannot move on.
// Reset: rst_ni clears all valid bits at once; the data registers are not reset.
// Top level of the ZYX Euler vector rotation; depends on ezr_pkg and ezr_matvec.
`default_nettype none

module euler_zyx_vector_rotate #(
  parameter int VEC_WIDTH      = 24,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic signed [ezr_pkg::TRIG_W-1:0]   cos_yaw_i,
  input  logic signed [ezr_pkg::TRIG_W-1:0]   sin_yaw_i,
  input  logic signed [ezr_pkg::TRIG_W-1:0]   cos_pitch_i,
  input  logic signed [ezr_pkg::TRIG_W-1:0]   sin_pitch_i,
  input  logic signed [ezr_pkg::TRIG_W-1:0]   cos_roll_i,
  input  logic signed [ezr_pkg::TRIG_W-1:0]   sin_roll_i,
  input  logic signed [VEC_WIDTH-1:0]         vec_x_i,
  input  logic signed [VEC_WIDTH-1:0]         vec_y_i,
  input  logic signed [VEC_WIDTH-1:0]         vec_z_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic signed [VEC_WIDTH-1:0]         out_x_o,
  output logic signed [VEC_WIDTH-1:0]         out_y_o,
  output logic signed [VEC_WIDTH-1:0]         out_z_o,
  output logic                                saturated_o
);
  import ezr_pkg::*;

  localparam int F    = TRIG_FRAC_BITS;
  localparam int P2_W = 2 * TRIG_W;
  localparam int P3_W = 3 * TRIG_W;
  // Sum of a triple product and a pair product scaled up by the fraction bits.
  localparam int S3_W = imax(P3_W, P2_W + F) + 2;
  // Matrix entries are kept wide enough that none of them ever clips,
  // including the exact negated pitch sine.
  localparam int ENT_W = imax(TRIG_W + 2, P3_W + 2 - 2 * F);

  localparam logic signed [P2_W:0]   RND2 = (P2_W + 1)'(1) << (F - 1);
  localparam logic signed [S3_W-1:0] RND3 = S3_W'(1) << (2 * F - 1);

  // Pair product slots in the first stage.
  localparam int PR_CPCY = 0;
  localparam int PR_CPSY = 1;
  localparam int PR_SRCP = 2;
  localparam int PR_CRCP = 3;
  localparam int PR_CRSY = 4;
  localparam int PR_SRSY = 5;
  localparam int PR_CRCY = 6;
  localparam int PR_SRCY = 7;
  localparam int PR_SRSP = 8;
  localparam int PR_CRSP = 9;
  localparam int PR_N    = 10;

  // Triple product slots in the second stage.
  localparam int TR_SRSPCY = 0;
  localparam int TR_CRSPCY = 1;
  localparam int TR_SRSPSY = 2;
  localparam int TR_CRSPSY = 3;
  localparam int TR_N      = 4;

  // Entries that need only one rounded pair product.
  localparam int E2_R00 = 0;
  localparam int E2_R10 = 1;
  localparam int E2_R21 = 2;
  localparam int E2_R22 = 3;
  localparam int E2_N   = 4;

  // Round half up of a pair product to the fraction grid.
  function automatic logic signed [ENT_W-1:0] round2(input logic signed [P2_W-1:0] p);
    logic signed [P2_W:0] s;
    s = (P2_W + 1)'(p) + RND2;
    return ENT_W'(s >>> F);
  endfunction

  // One rounding of triple / 2^2F plus or minus pair / 2^F.
  function automatic logic signed [ENT_W-1:0] round3(input logic signed [P3_W-1:0] t,
                                                     input logic signed [P2_W-1:0] p,
                                                     input logic               neg);
    logic signed [S3_W-1:0] pe;
    logic signed [S3_W-1:0] s;
    pe = S3_W'(p) <<< F;
    if (neg) begin
      s = S3_W'(t) - pe + RND3;
    end else begin
      s = S3_W'(t) + pe + RND3;
    end
    return ENT_W'(s >>> (2 * F));
  endfunction

  // Valid bits and load enables of the three matrix stages.
  logic [2:0] vld_q, vld_d;
  logic [2:0] en;
  logic       mv_stall;

  // Stage one: the ten pair products, plus operands needed later.
  logic signed [P2_W-1:0]      p_q [PR_N];
  logic signed [P2_W-1:0]      p_d [PR_N];
  logic signed [TRIG_W-1:0]    cy1_q, sy1_q, sp1_q;
  logic signed [VEC_WIDTH-1:0] vec1_q [VEC_N];
  logic signed [VEC_WIDTH-1:0] vec1_d [VEC_N];

  // Stage two: triple products, single-product entries, kept pairs.
  logic signed [P3_W-1:0]      t_q  [TR_N];
  logic signed [P3_W-1:0]      t_d  [TR_N];
  logic signed [ENT_W-1:0]     e2_q [E2_N];
  logic signed [ENT_W-1:0]     e2_d [E2_N];
  logic signed [P2_W-1:0]      crsy2_q, srsy2_q, crcy2_q, srcy2_q;
  logic signed [TRIG_W-1:0]    sp2_q;
  logic signed [VEC_WIDTH-1:0] vec2_q [VEC_N];

  // Stage three: the finished matrix, row by row.
  logic signed [ENT_W-1:0]     ent_q [MAT_N];
  logic signed [ENT_W-1:0]     ent_d [MAT_N];
  logic signed [VEC_WIDTH-1:0] vec3_q [VEC_N];

  // Each stage loads when empty or when the next one takes its request.
  assign en[2]   = !vld_q[2] || !mv_stall;
  assign en[1]   = !vld_q[1] || en[2];
  assign en[0]   = !vld_q[0] || en[1];
  assign stall_o = !en[0];

  always_comb begin
    vld_d[0] = en[0] ? valid_i  : vld_q[0];
    vld_d[1] = en[1] ? vld_q[0] : vld_q[1];
    vld_d[2] = en[2] ? vld_q[1] : vld_q[2];
  end

  // Stage one: all 16 x 16 products of the matrix, independent of each other.
  always_comb begin
    p_d[PR_CPCY] = P2_W'(cos_pitch_i) * P2_W'(cos_yaw_i);
    p_d[PR_CPSY] = P2_W'(cos_pitch_i) * P2_W'(sin_yaw_i);
    p_d[PR_SRCP] = P2_W'(sin_roll_i)  * P2_W'(cos_pitch_i);
    p_d[PR_CRCP] = P2_W'(cos_roll_i)  * P2_W'(cos_pitch_i);
    p_d[PR_CRSY] = P2_W'(cos_roll_i)  * P2_W'(sin_yaw_i);
    p_d[PR_SRSY] = P2_W'(sin_roll_i)  * P2_W'(sin_yaw_i);
    p_d[PR_CRCY] = P2_W'(cos_roll_i)  * P2_W'(cos_yaw_i);
    p_d[PR_SRCY] = P2_W'(sin_roll_i)  * P2_W'(cos_yaw_i);
    p_d[PR_SRSP] = P2_W'(sin_roll_i)  * P2_W'(sin_pitch_i);
    p_d[PR_CRSP] = P2_W'(cos_roll_i)  * P2_W'(sin_pitch_i);
    vec1_d[0] = vec_x_i;
    vec1_d[1] = vec_y_i;
    vec1_d[2] = vec_z_i;
  end

  // Stage two: roll-pitch pairs times the yaw terms, and the four entries
  // that come from a single pair product are rounded here.
  always_comb begin
    t_d[TR_SRSPCY] = P3_W'(p_q[PR_SRSP]) * P3_W'(cy1_q);
    t_d[TR_CRSPCY] = P3_W'(p_q[PR_CRSP]) * P3_W'(cy1_q);
    t_d[TR_SRSPSY] = P3_W'(p_q[PR_SRSP]) * P3_W'(sy1_q);
    t_d[TR_CRSPSY] = P3_W'(p_q[PR_CRSP]) * P3_W'(sy1_q);
    e2_d[E2_R00]   = round2(p_q[PR_CPCY]);
    e2_d[E2_R10]   = round2(p_q[PR_CPSY]);
    e2_d[E2_R21]   = round2(p_q[PR_SRCP]);
    e2_d[E2_R22]   = round2(p_q[PR_CRCP]);
  end

  // Stage three: combine each triple with its pair under a single rounding.
  // The bottom-left entry is the negated pitch sine and is exact.
  always_comb begin
    ent_d[0] = e2_q[E2_R00];
    ent_d[1] = round3(t_q[TR_SRSPCY], crsy2_q, 1'b1);
    ent_d[2] = round3(t_q[TR_CRSPCY], srsy2_q, 1'b0);
    ent_d[3] = e2_q[E2_R10];
    ent_d[4] = round3(t_q[TR_SRSPSY], crcy2_q, 1'b0);
    ent_d[5] = round3(t_q[TR_CRSPSY], srcy2_q, 1'b1);
    ent_d[6] = -ENT_W'(sp2_q);
    ent_d[7] = e2_q[E2_R21];
    ent_d[8] = e2_q[E2_R22];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_q    <= p_d;
      cy1_q  <= cos_yaw_i;
      sy1_q  <= sin_yaw_i;
      sp1_q  <= sin_pitch_i;
      vec1_q <= vec1_d;
    end
    if (en[1]) begin
      t_q     <= t_d;
      e2_q    <= e2_d;
      crsy2_q <= p_q[PR_CRSY];
      srsy2_q <= p_q[PR_SRSY];
      crcy2_q <= p_q[PR_CRCY];
      srcy2_q <= p_q[PR_SRCY];
      sp2_q   <= sp1_q;
      vec2_q  <= vec1_q;
    end
    if (en[2]) begin
      ent_q  <= ent_d;
      vec3_q <= vec2_q;
    end
  end

  // Matrix times vector, rounding and saturation, three more stages.
  ezr_matvec #(
    .VEC_WIDTH (VEC_WIDTH),
    .ENT_W     (ENT_W),
    .FRAC_BITS (F)
  ) u_matvec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (vld_q[2]),
    .stall_o     (mv_stall),
    .mat_i       (ent_q),
    .vec_i       (vec3_q),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .saturated_o (saturated_o)
  );

  // Requests are refused only when the matrix stages are all occupied.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (vld_q[0] && vld_q[1] && vld_q[2]))
    else $error("euler_zyx_vector_rotate: stalled with an empty stage");

  // A finished matrix held by the downstream unit keeps its request and entries.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[2] && !en[2]) |=> (vld_q[2] && $stable(ent_q[1]) && $stable(vec3_q[0])))
    else $error("euler_zyx_vector_rotate: held matrix changed");

  // The bottom-left entry is exactly the negated pitch sine of the same request.
  a_neg_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[1] && en[2]) |=> (ent_q[6] == -$past(ENT_W'(sp2_q))))
    else $error("euler_zyx_vector_rotate: bottom-left entry mismatch");

endmodule

`default_nettype wire
